/* rtl/core/bba_pkg.sv */
package bba_pkg;

   // Bitmap words are scanned one per cycle.
   localparam int WORD_BITS       = 64;
   localparam int WORD_SEL_W      = 6;

   // Block size is fixed at a power of two so an offset maps to a block by a shift.
   localparam int BLOCK_SHIFT     = 5;
   localparam int BLOCK_BYTES     = 1 << BLOCK_SHIFT;

   localparam int DEF_BLOCKS_PER_PAGE = 1024;
   localparam int DEF_NUM_PAGES       = 4;

   localparam int FREE_OFFSET_W   = 18;
   localparam int BLOCK_OFFSET_W  = 17;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE
   } bba_state_type;

endpackage

/* rtl/core/bitmap_block_allocator_core.sv */
// Fixed-size block allocator over a free bitmap, first fit in page order.
// Command channel: a beat is taken at a rising edge with req_start high and
// req_busy low. req_cmd selects allocate (lowest free block is marked used) or
// free (the block holding byte req_free_offset is marked free).
// Response channel: exactly one beat per command, shown for one cycle with
// rsp_strobe high. rsp_ok flags success; rsp_block_offset carries the byte
// offset of an allocated block and reads zero otherwise. The receiver cannot
// stall; the response register is separate from the sequencer, so a new
// command may be issued in the same cycle a response is shown.
// Sequence, from the start edge to the response beat:
//   allocate: bitmap words are scanned from word 0 upward until one holds a
//     free block or the last word is checked; the bitmap memory delivers one
//     word per cycle and sets the scan rate.
//   free inside the pool: read-modify-write of one word.
//   free outside the pool: the failure response is registered straight from idle.
// req_busy is high while a command is in progress; the next command can be
// taken at the edge that takes the response, so commands never overlap.
// Reset: synchronous, active high. Every block reads as free right after
// reset: one valid flop per bitmap word marks words never written, which read
// as all free. No clearing pass is needed.
module bitmap_block_allocator_core
   import bba_pkg::*;
#(
   parameter int BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE,
   parameter int NUM_PAGES       = DEF_NUM_PAGES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      req_busy,
   input  logic                      req_cmd,
   input  logic [FREE_OFFSET_W-1:0]  req_free_offset,
   output logic                      rsp_strobe,
   output logic                      rsp_ok,
   output logic [BLOCK_OFFSET_W-1:0] rsp_block_offset
);

   localparam int TOTAL_BLOCKS = BLOCKS_PER_PAGE * NUM_PAGES;
   localparam int MAP_WORDS    = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int LAST_ROW     = MAP_WORDS - 1;
   localparam int TAIL_BITS    = TOTAL_BLOCKS - LAST_ROW * WORD_BITS;
   localparam logic [WORD_BITS-1:0] TAIL_MASK =
      (TAIL_BITS == WORD_BITS) ? {WORD_BITS{1'b1}}
                               : ((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));
   // Offset compare is done wide enough to hold the pool size.
   localparam int POOL_W       = $clog2(TOTAL_BLOCKS) + BLOCK_SHIFT + 2;
   localparam logic [POOL_W-1:0] POOL_BYTES = POOL_W'(TOTAL_BLOCKS) << BLOCK_SHIFT;
   localparam int FREE_IDX_W   = FREE_OFFSET_W - BLOCK_SHIFT;

   // Bitmap memory, 1 = free; valid flop per word, invalid words read all free.
   logic [WORD_BITS-1:0] free_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] row_valid_ff;

   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [ROW_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [ROW_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   bba_state_type        state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [WORD_SEL_W-1:0] bit_ff, bit_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic [BLOCK_OFFSET_W-1:0] rsp_block_offset_ff, rsp_block_offset_in;

   logic [WORD_BITS-1:0]  row_word;
   logic [WORD_BITS-1:0]  scan_word;
   logic                  hit;
   logic [WORD_SEL_W-1:0] hit_bit;
   logic                  free_in_pool;
   logic [FREE_IDX_W-1:0] free_idx;
   logic [ROW_W-1:0]      next_row;

   // ---------------- bitmap memory ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= free_mem[rd_addr];
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Word as stored, and as seen by the scan (blocks past the pool are used).
   assign row_word  = rd_valid_ff ? rd_data_ff : {WORD_BITS{1'b1}};
   assign scan_word = (row_ff == ROW_W'(LAST_ROW)) ? (row_word & TAIL_MASK) : row_word;

   // Lowest set bit of the scanned word.
   always_comb begin
      hit     = |scan_word;
      hit_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (scan_word[i]) begin
            hit_bit = WORD_SEL_W'(i);
         end
      end
   end

   assign free_in_pool = ({{(POOL_W-FREE_OFFSET_W){1'b0}}, req_free_offset} < POOL_BYTES);
   assign free_idx     = req_free_offset[FREE_OFFSET_W-1:BLOCK_SHIFT];
   assign next_row     = (row_ff == ROW_W'(LAST_ROW)) ? '0 : row_ff + ROW_W'(1);

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff              <= row_in;
      bit_ff              <= bit_in;
      rsp_ok_ff           <= rsp_ok_in;
      rsp_block_offset_ff <= rsp_block_offset_in;
   end

   always_comb begin
      state_in            = state_ff;
      row_in              = row_ff;
      bit_in              = bit_ff;
      rd_addr             = '0;
      wr_en               = 1'b0;
      wr_addr             = row_ff;
      wr_data             = row_word;
      rsp_strobe_in       = 1'b0;
      rsp_ok_in           = rsp_ok_ff;
      rsp_block_offset_in = rsp_block_offset_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               if (req_cmd == CMD_ALLOC) begin
                  row_in   = '0;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end else if (free_in_pool) begin
                  row_in   = ROW_W'(free_idx >> WORD_SEL_W);
                  bit_in   = free_idx[WORD_SEL_W-1:0];
                  rd_addr  = ROW_W'(free_idx >> WORD_SEL_W);
                  state_in = ST_FREE;
               end else begin
                  rsp_strobe_in       = 1'b1;
                  rsp_ok_in           = 1'b0;
                  rsp_block_offset_in = '0;
               end
            end
         end
         ST_SCAN: begin
            // Next word is fetched speculatively so one word is checked per cycle.
            rd_addr = next_row;
            if (hit) begin
               wr_en               = 1'b1;
               wr_data             = row_word & ~(WORD_BITS'(1) << hit_bit);
               rsp_strobe_in       = 1'b1;
               rsp_ok_in           = 1'b1;
               rsp_block_offset_in =
                  BLOCK_OFFSET_W'({row_ff, hit_bit, {BLOCK_SHIFT{1'b0}}});
               state_in            = ST_IDLE;
            end else if (row_ff == ROW_W'(LAST_ROW)) begin
               rsp_strobe_in       = 1'b1;
               rsp_ok_in           = 1'b0;
               rsp_block_offset_in = '0;
               state_in            = ST_IDLE;
            end else begin
               row_in = next_row;
            end
         end
         ST_FREE: begin
            // Freeing an already free block leaves it free and still succeeds.
            wr_en               = 1'b1;
            wr_data             = row_word | (WORD_BITS'(1) << bit_ff);
            rsp_strobe_in       = 1'b1;
            rsp_ok_in           = 1'b1;
            rsp_block_offset_in = '0;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_busy         = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_block_offset = rsp_block_offset_ff;

   // ---------------- assertions ----------------
   // A response beat always follows an accepted command or a finishing step.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_busy || req_start))
      else $error("response beat without a command");

   // The sequencer is back in idle whenever a response is shown.
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("response shown while sequencer busy");

   // Failed commands report a zero offset.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_block_offset == '0))
      else $error("failure with nonzero offset");

   // Every bitmap write is the last step of a command and raises its response.
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_strobe)
      else $error("bitmap write without a response");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb
   import bba_pkg::*;
();

   localparam int TOTAL_BLOCKS = DEF_BLOCKS_PER_PAGE * DEF_NUM_PAGES;
   localparam int POOL_BYTES   = TOTAL_BLOCKS * BLOCK_BYTES;
   localparam int RANDOM_CMDS  = 560;

   // One command beat waiting to go out.
   typedef struct {
      logic                     cmd;
      logic [FREE_OFFSET_W-1:0] offset;
      bit                       drain;   // hold off until every response is in
      bit                       steady;  // no random idling for this beat
   } alloc_cmd_type;

   // One response beat.
   typedef struct {
      logic                      ok;
      logic [BLOCK_OFFSET_W-1:0] block_offset;
   } alloc_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_start = 1'b0;
   logic                      req_busy;
   logic                      req_cmd = CMD_ALLOC;
   logic [FREE_OFFSET_W-1:0]  req_free_offset = '0;
   logic                      rsp_strobe;
   logic                      rsp_ok;
   logic [BLOCK_OFFSET_W-1:0] rsp_block_offset;

   alloc_cmd_type cmd_backlog[$];
   alloc_rsp_type rsp_due[$];

   // Shadow of the allocator bitmap, 1 = block free.
   bit shadow_free [TOTAL_BLOCKS] = '{default: 1'b1};

   int miss_count = 0;
   int live_blocks = 0;  // rough count of blocks held, steers frees toward used ones

   bitmap_block_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_start        (req_start),
      .req_busy         (req_busy),
      .req_cmd          (req_cmd),
      .req_free_offset  (req_free_offset),
      .rsp_strobe       (rsp_strobe),
      .rsp_ok           (rsp_ok),
      .rsp_block_offset (rsp_block_offset)
   );

   always #4 clock = ~clock;

   // First fit over the shadow bitmap; frees take the block holding the byte.
   function automatic alloc_rsp_type first_fit_step(logic cmd, logic [FREE_OFFSET_W-1:0] off);
      alloc_rsp_type r;
      int            idx;
      r.ok = 1'b0;
      r.block_offset = '0;
      if (cmd == CMD_ALLOC) begin
         for (idx = 0; idx < TOTAL_BLOCKS; idx++) begin
            if (shadow_free[idx]) begin
               shadow_free[idx] = 1'b0;
               r.ok = 1'b1;
               r.block_offset = BLOCK_OFFSET_W'(idx * BLOCK_BYTES);
               break;
            end
         end
      end else if (off < POOL_BYTES) begin
         idx = int'(off >> BLOCK_SHIFT);
         shadow_free[idx] = 1'b1;
         r.ok = 1'b1;
      end
      return r;
   endfunction

   task automatic queue_cmd(logic cmd, logic [FREE_OFFSET_W-1:0] off, bit drain = 1'b0);
      alloc_cmd_type c;
      c.cmd = cmd;
      c.offset = off;
      c.drain = drain;
      // a long run of back-to-back beats early in the random part
      c.steady = (cmd_backlog.size() >= 150 && cmd_backlog.size() < 330);
      cmd_backlog.push_back(c);
      if (cmd == CMD_ALLOC) live_blocks++;
      else if (live_blocks > 0) live_blocks--;
   endtask

   task automatic queue_alloc(bit drain = 1'b0);
      // offset is don't-care on allocate; drive noise on it
      queue_cmd(CMD_ALLOC, FREE_OFFSET_W'($urandom_range(0, (1 << FREE_OFFSET_W) - 1)), drain);
   endtask

   task automatic queue_free_near();
      int idx;
      idx = $urandom_range(0, live_blocks + 8);
      if (idx >= TOTAL_BLOCKS) idx = TOTAL_BLOCKS - 1;
      queue_cmd(CMD_FREE,
                FREE_OFFSET_W'(idx * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1)));
   endtask

   // Driver: presents the head of the backlog at the falling edge.
   always @(negedge clock) begin
      logic go;
      go = 1'b0;
      if (!reset && cmd_backlog.size() != 0) begin
         if (cmd_backlog[0].drain && rsp_due.size() != 0) begin
            go = 1'b0;
         end else begin
            cmd_backlog[0].drain = 1'b0;
            go = cmd_backlog[0].steady || ($urandom_range(0, 99) >= 22);
         end
      end
      req_start <= go;
      if (go) begin
         req_cmd         <= cmd_backlog[0].cmd;
         req_free_offset <= cmd_backlog[0].offset;
      end else begin
         req_cmd         <= 1'($urandom_range(0, 1));
         req_free_offset <= FREE_OFFSET_W'($urandom_range(0, (1 << FREE_OFFSET_W) - 1));
      end
   end

   // Monitor: checks the response beat, then books the command beat taken at
   // this same edge (its response can only show up later).
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (rsp_due.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("%0t: response beat with none pending: ok=%b offset=%0d",
                           $realtime, rsp_ok, rsp_block_offset);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_ok !== want.ok || rsp_block_offset !== want.block_offset) begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display("%0t: mismatch: ok exp %b got %b, offset exp %0d got %0d",
                              $realtime, want.ok, rsp_ok, want.block_offset,
                              rsp_block_offset);
               end
            end
         end
         if (req_start === 1'b1 && req_busy === 1'b0) begin
            rsp_due.push_back(first_fit_step(req_cmd, req_free_offset));
            void'(cmd_backlog.pop_front());
         end
      end
   end

   initial begin
      int n;
      int pick;

      // Directed: first fit order, unaligned and repeated frees, pool edges.
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_ALLOC, '1);
      queue_alloc();
      queue_alloc();
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(BLOCK_BYTES));           // aligned
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(3 * BLOCK_BYTES - 1));   // last byte of a block
      queue_alloc();                                              // reuses lowest hole
      queue_alloc();
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(4000 * BLOCK_BYTES + 7)); // already free
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(POOL_BYTES - 1));         // last byte in pool
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(POOL_BYTES));             // first byte outside
      queue_cmd(CMD_FREE, '1);                                     // max offset
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(POOL_BYTES + 12345));
      queue_cmd(CMD_FREE, '0);
      queue_alloc();
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(POOL_BYTES - BLOCK_BYTES));
      queue_cmd(CMD_FREE, FREE_OFFSET_W'(BLOCK_BYTES + 5));
      queue_alloc();

      // Random mix, mostly alloc/free pairs on blocks likely held.
      for (n = 0; n < RANDOM_CMDS; n++) begin
         pick = $urandom_range(0, 99);
         if (n == 0)
            queue_alloc(1'b1);
         else if (pick < 45)
            queue_alloc();
         else if (pick < 85)
            queue_free_near();
         else if (pick < 92)
            queue_cmd(CMD_FREE, FREE_OFFSET_W'($urandom_range(0, POOL_BYTES - 1)));
         else
            queue_cmd(CMD_FREE,
                      FREE_OFFSET_W'($urandom_range(POOL_BYTES, (1 << FREE_OFFSET_W) - 1)));
      end

      // Punch holes anywhere in the pool, then keep allocating into them.
      for (n = 0; n < 40; n++) begin
         if (n % 3 == 0)
            queue_alloc();
         else
            queue_cmd(CMD_FREE, FREE_OFFSET_W'($urandom_range(0, POOL_BYTES - 1)));
      end
      for (n = 0; n < 30; n++) queue_alloc();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0) @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
      // longest allocate scan plus margin, to catch stray response beats
      repeat (100) @(posedge clock);

      if (miss_count == 0 && rsp_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/bba_pkg.sv
rtl/core/bitmap_block_allocator_core.sv
sim/tb.sv
